[rtl/sld_pkg.sv]
// ----------------------------------------------------------------------------
// sld_pkg - shared types and constants of the slew limited motor drive
// Word formats, register indexes, power limits and the linearization table.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int TABLE_ENTRIES = 101;
    localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CFG_DATA_W    = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int POWER_W       = 16;
    localparam int TARGET_W      = 8;
    localparam int LIM_W         = 20;
    localparam int STATE_W       = POWER_W + TARGET_W;

    localparam logic signed [POWER_W-1:0] POWER_LIMIT = 16'sd25600;

    localparam logic       SLEW_ENABLE_RST = 1'b1;
    localparam logic [9:0] SLEW_STEP_RST   = 10'd171;
    localparam logic       REVERSED_RST    = 1'b0;
    localparam logic [3:0] MOTOR_PORT_RST  = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEW_ENABLE = 2'd0,
        CFG_SLEW_STEP   = 2'd1,
        CFG_REVERSED    = 2'd2,
        CFG_MOTOR_PORT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              func;
        logic signed [7:0] req_power;
        logic [9:0]        interval_ms;
    } t_in_word;

    typedef struct packed {
        logic               drive_valid;
        logic [3:0]         drive_port;
        logic signed [7:0]  drive_value;
        logic signed [15:0] current_power;
    } t_out_word;

    localparam logic [6:0] SPEED_TABLE [0:TABLE_ENTRIES-1] = '{
        7'd0,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd17, 7'd17,
        7'd17, 7'd17, 7'd18, 7'd19, 7'd19, 7'd20, 7'd20, 7'd20, 7'd20, 7'd21,
        7'd22, 7'd22, 7'd22, 7'd23, 7'd24, 7'd24, 7'd24, 7'd24, 7'd25, 7'd25,
        7'd26, 7'd26, 7'd27, 7'd27, 7'd28, 7'd28, 7'd28, 7'd28, 7'd29, 7'd29,
        7'd29, 7'd30, 7'd31, 7'd31, 7'd31, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34,
        7'd35, 7'd35, 7'd35, 7'd36, 7'd36, 7'd37, 7'd38, 7'd38, 7'd39, 7'd39,
        7'd40, 7'd41, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd47,
        7'd48, 7'd50, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
        7'd57, 7'd58, 7'd61, 7'd61, 7'd62, 7'd62, 7'd64, 7'd65, 7'd66, 7'd66,
        7'd68, 7'd69, 7'd69, 7'd69, 7'd70, 7'd85, 7'd90, 7'd100, 7'd100, 7'd100
    };

endpackage

[rtl/slew_limited_motor_drive.sv]
// ----------------------------------------------------------------------------
// slew_limited_motor_drive - slew limited power ramp with drive linearization
// Usage:
//   input channel  i_valid / o_stall / i_word : set-target words (func 0)
//     and update ticks (func 1 with elapsed milliseconds)
//   output channel o_valid / i_stall / o_word : one word per input word;
//     ticks carry the linearized drive command, set-target words report
//     the present power with drive_valid low
//   config port i_cfg_we / i_cfg_idx / i_cfg_data, written while idle:
//     0 slew enable, 1 slew step, 2 direction reversed, 3 motor port
// A word accepted into the read stage register moves on through the update
// stage register to the output register.
// Throughput is one word per cycle unless the output stalls; power and target
// sit in a one entry ram that each word reads on acceptance and writes back as
// it leaves the read stage, with a bypass for the word that follows directly.
// Reset clears config to its defaults and power and target to zero,
// no clearing pass is needed.
// When the receiver stalls the result holds, up to two more words are still
// taken into the pipeline, then o_stall rises.
// ----------------------------------------------------------------------------
module slew_limited_motor_drive
    import sld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        logic                       func;
        logic signed [TARGET_W-1:0] req_power;
        logic [LIM_W-1:0]           lim;
    } t_s1;

    typedef struct packed {
        logic                      tick;
        logic signed [POWER_W-1:0] power;
    } t_s2;

    logic       r_slew_en;
    logic [9:0] r_slew_step;
    logic       r_reversed;
    logic [3:0] r_motor_port;

    logic      r_s1_v, r_s2_v, r_out_v;
    t_s1       r_s1;
    t_s2       r_s2;
    t_out_word r_out;

    logic               r_byp_sel;
    logic               r_mem_ok;
    logic [STATE_W-1:0] r_byp_data;

    logic ld3, ld2, ld1, s1_go, accept;

    logic [STATE_W-1:0] ram_q;
    logic [STATE_W-1:0] wr_data;
    logic [STATE_W-1:0] state_q;

    logic signed [POWER_W-1:0]  pw, tq, pw_upd, pw_clamp;
    logic signed [TARGET_W-1:0] tgt, n_tgt;
    logic [POWER_W-1:0]         mag_tq, mag_pw;
    logic signed [POWER_W:0]    diff;
    logic [POWER_W:0]           mag_diff, chg;
    logic signed [POWER_W+1:0]  stepped;
    logic                       cancel;

    logic [POWER_W-1:0]     mag_out;
    logic [POWER_W-1:0]     rnd;
    logic [7:0]             m_pct;
    logic [TABLE_IDX_W-1:0] tbl_idx;
    logic [6:0]             tbl_val;
    logic                   out_neg;
    t_out_word              n_out;

    // handshake and pipeline advance
    assign ld3    = !r_out_v || !i_stall;
    assign ld2    = !r_s2_v || ld3;
    assign ld1    = !r_s1_v || ld2;
    assign s1_go  = r_s1_v && ld2;
    assign accept = i_valid && ld1;
    assign o_stall = !ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_en    <= SLEW_ENABLE_RST;
            r_slew_step  <= SLEW_STEP_RST;
            r_reversed   <= REVERSED_RST;
            r_motor_port <= MOTOR_PORT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SLEW_ENABLE: r_slew_en    <= i_cfg_data[0];
                CFG_SLEW_STEP:   r_slew_step  <= i_cfg_data[9:0];
                CFG_REVERSED:    r_reversed   <= i_cfg_data[0];
                CFG_MOTOR_PORT:  r_motor_port <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    sld_ram #(
        .WIDTH (STATE_W),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (1'b0),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (1'b0),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_mem_ok <= 1'b0;
        end else begin
            if (ld1) begin
                r_s1_v <= i_valid;
            end
            if (ld2) begin
                r_s2_v <= r_s1_v;
            end
            if (ld3) begin
                r_out_v <= r_s2_v;
            end
            if (s1_go) begin
                r_mem_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.func      <= i_word.func;
            r_s1.req_power <= i_word.req_power;
            r_s1.lim       <= LIM_W'(r_slew_step) * LIM_W'(i_word.interval_ms);
            r_byp_sel      <= s1_go;
            r_byp_data     <= wr_data;
        end
        if (s1_go) begin
            r_s2.tick  <= r_s1.func;
            r_s2.power <= pw_clamp;
        end
        if (ld3 && r_s2_v) begin
            r_out <= n_out;
        end
    end

    // state read with bypass of the write-back from the word just ahead
    always_comb begin
        if (r_byp_sel) begin
            state_q = r_byp_data;
        end else if (r_mem_ok) begin
            state_q = ram_q;
        end else begin
            state_q = '0;
        end
        pw  = state_q[POWER_W-1:0];
        tgt = state_q[STATE_W-1:POWER_W];
    end

    // slew rule
    always_comb begin
        tq       = {tgt, 8'h00};
        mag_tq   = tq[POWER_W-1] ? POWER_W'(-tq) : POWER_W'(tq);
        mag_pw   = pw[POWER_W-1] ? POWER_W'(-pw) : POWER_W'(pw);
        cancel   = (tq == '0 && pw == '0) || (tq > 0 && pw < 0) || (tq < 0 && pw > 0);
        diff     = (POWER_W+1)'(tq) - (POWER_W+1)'(pw);
        mag_diff = diff[POWER_W] ? (POWER_W+1)'(-diff) : (POWER_W+1)'(diff);
        chg      = (r_s1.lim < LIM_W'(mag_diff)) ? r_s1.lim[POWER_W:0] : mag_diff;
        stepped  = diff[POWER_W] ? (POWER_W+2)'(pw) - (POWER_W+2)'({1'b0, chg})
                                 : (POWER_W+2)'(pw) + (POWER_W+2)'({1'b0, chg});
        n_tgt    = tgt;
        pw_upd   = pw;
        if (!r_s1.func) begin
            n_tgt = r_s1.req_power;
            if (!r_slew_en) begin
                pw_upd = {r_s1.req_power, 8'h00};
            end
        end else if (r_slew_en) begin
            if (cancel) begin
                pw_upd = '0;
            end else if (mag_tq < mag_pw) begin
                pw_upd = tq;
            end else begin
                pw_upd = stepped[POWER_W-1:0];
            end
        end
        pw_clamp = pw_upd;
        if (r_s1.func) begin
            if (pw_upd > POWER_LIMIT) begin
                pw_clamp = POWER_LIMIT;
            end else if (pw_upd < -POWER_LIMIT) begin
                pw_clamp = -POWER_LIMIT;
            end
        end
        wr_data = {n_tgt, pw_clamp};
    end

    // rounding, reversal and linearization
    always_comb begin
        mag_out = r_s2.power[POWER_W-1] ? POWER_W'(-r_s2.power) : POWER_W'(r_s2.power);
        rnd     = mag_out + POWER_W'(128);
        m_pct   = rnd[15:8];
        if (m_pct > 8'(TABLE_ENTRIES - 1)) begin
            tbl_idx = TABLE_IDX_W'(TABLE_ENTRIES - 1);
        end else begin
            tbl_idx = m_pct[TABLE_IDX_W-1:0];
        end
        tbl_val = SPEED_TABLE[tbl_idx];
        out_neg = r_s2.power[POWER_W-1] ^ r_reversed;
        n_out.current_power = r_s2.power;
        if (r_s2.tick) begin
            n_out.drive_valid = 1'b1;
            n_out.drive_port  = r_motor_port;
            n_out.drive_value = out_neg ? -$signed({1'b0, tbl_val}) : $signed({1'b0, tbl_val});
        end else begin
            n_out.drive_valid = 1'b0;
            n_out.drive_port  = '0;
            n_out.drive_value = '0;
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out;

`ifndef SYNTHESIS
    a_tick_power_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1.func) |-> (pw_clamp <= POWER_LIMIT && pw_clamp >= -POWER_LIMIT))
        else $error("tick left power beyond limit");

    a_bypass_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_byp_sel) |-> r_mem_ok)
        else $error("bypass selected before any state write-back");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !ld2) |=> (r_s1_v && $stable(r_s1) && $stable(state_q)))
        else $error("stalled read stage lost its word or state");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.drive_value <= 8'sd100 && o_word.drive_value >= -8'sd100))
        else $error("drive value out of range");

    a_idle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.drive_valid) |-> (o_word.drive_value == '0 && o_word.drive_port == '0))
        else $error("set-target word carries a drive command");
`endif

endmodule

[rtl/sld_ram.sv]
// ----------------------------------------------------------------------------
// sld_ram - generic single write port ram with registered read
// One write and one read per cycle; read returns the old data on collision.
// ----------------------------------------------------------------------------
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[verif/sld_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sld_tb_pkg - word codes shared by the motor drive checker and testbench
// Function codes carried in the func field of an input word.
// ----------------------------------------------------------------------------
package sld_tb_pkg;

    localparam logic FUNC_SET_TARGET = 1'b0;
    localparam logic FUNC_TICK       = 1'b1;

endpackage

[verif/slew_limited_motor_drive_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slew_limited_motor_drive_checker - drive command predictor and comparator
// Watches the input, output and register ports of the motor drive, keeps its
// own copy of power, target and registers, predicts the drive word for every
// accepted input word and checks each output word field by field in order.
// ----------------------------------------------------------------------------
module slew_limited_motor_drive_checker
    import sld_pkg::*;
    import sld_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_ticks,
    output int                    o_targets
);

    localparam int POWER_CAP_Q8 = 25600;
    localparam int LAST_ENTRY   = 100;

    localparam logic [6:0] LIN_TABLE [0:100] = '{
        7'd0,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd17, 7'd17,
        7'd17, 7'd17, 7'd18, 7'd19, 7'd19, 7'd20, 7'd20, 7'd20, 7'd20, 7'd21,
        7'd22, 7'd22, 7'd22, 7'd23, 7'd24, 7'd24, 7'd24, 7'd24, 7'd25, 7'd25,
        7'd26, 7'd26, 7'd27, 7'd27, 7'd28, 7'd28, 7'd28, 7'd28, 7'd29, 7'd29,
        7'd29, 7'd30, 7'd31, 7'd31, 7'd31, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34,
        7'd35, 7'd35, 7'd35, 7'd36, 7'd36, 7'd37, 7'd38, 7'd38, 7'd39, 7'd39,
        7'd40, 7'd41, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd47,
        7'd48, 7'd50, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
        7'd57, 7'd58, 7'd61, 7'd61, 7'd62, 7'd62, 7'd64, 7'd65, 7'd66, 7'd66,
        7'd68, 7'd69, 7'd69, 7'd69, 7'd70, 7'd85, 7'd90, 7'd100, 7'd100, 7'd100
    };

    logic               slew_on;
    logic [9:0]         step_q8;
    logic               reversed;
    logic [3:0]         port_no;
    logic signed [16:0] power_q8;
    logic signed [7:0]  target_pct;

    t_out_word expected_drives [$];
    t_out_word got;
    t_out_word want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_ticks      = 0;
        o_targets    = 0;
    end

    function automatic int sgn(input int v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_out_word next_drive(input t_in_word w);
        t_out_word r;
        int p, tq, diff, lim, d, m, sp, idx;
        r = '0;
        if (w.func == FUNC_SET_TARGET) begin
            target_pct = w.req_power;
            if (!slew_on) begin
                power_q8 = 17'(int'($signed(w.req_power)) * 256);
            end
            r.current_power = power_q8[15:0];
            return r;
        end
        p = int'(power_q8);
        if (slew_on) begin
            tq = int'(target_pct) * 256;
            if (sgn(tq) + sgn(p) == 0) begin
                p = 0;
            end else if (mag(tq) < mag(p)) begin
                p = tq;
            end else begin
                diff = tq - p;
                lim  = int'(step_q8) * int'(w.interval_ms);
                d    = mag(diff);
                p    = p + ((lim < d) ? lim : d) * sgn(diff);
            end
        end
        if (p > POWER_CAP_Q8) p = POWER_CAP_Q8;
        if (p < -POWER_CAP_Q8) p = -POWER_CAP_Q8;
        power_q8 = 17'(p);
        // round half away from zero to whole percent
        m  = (mag(p) + 128) >>> 8;
        sp = (p < 0) ? -m : m;
        if (reversed) sp = -sp;
        idx = mag(sp);
        if (idx > LAST_ENTRY) idx = LAST_ENTRY;
        r.drive_valid   = 1'b1;
        r.drive_port    = port_no;
        r.drive_value   = 8'(int'(LIN_TABLE[idx]) * sgn(sp));
        r.current_power = power_q8[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slew_on    = 1'b1;
            step_q8    = 10'd171;
            reversed   = 1'b0;
            port_no    = 4'd0;
            power_q8   = '0;
            target_pct = '0;
            expected_drives.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (expected_drives.size() == 0) begin
                    $error("drive word with nothing expected: %h", got);
                    o_mismatches++;
                end else begin
                    want = expected_drives.pop_front();
                    if (got.drive_valid !== want.drive_valid) begin
                        $error("drive_valid: expected %0d, got %0d",
                               want.drive_valid, got.drive_valid);
                        o_mismatches++;
                    end
                    if (got.drive_port !== want.drive_port) begin
                        $error("drive_port: expected %0d, got %0d",
                               want.drive_port, got.drive_port);
                        o_mismatches++;
                    end
                    if (got.drive_value !== want.drive_value) begin
                        $error("drive_value: expected %0d, got %0d",
                               $signed(want.drive_value), $signed(got.drive_value));
                        o_mismatches++;
                    end
                    if (got.current_power !== want.current_power) begin
                        $error("current_power: expected %0d, got %0d",
                               $signed(want.current_power), $signed(got.current_power));
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SLEW_ENABLE: slew_on  = i_cfg_data[0];
                    CFG_SLEW_STEP:   step_q8  = i_cfg_data[9:0];
                    CFG_REVERSED:    reversed = i_cfg_data[0];
                    CFG_MOTOR_PORT:  port_no  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_drives.push_back(next_drive(i_in_word));
                if (i_in_word.func == FUNC_TICK) o_ticks++;
                else o_targets++;
            end
        end
        o_pending = expected_drives.size();
    end

endmodule

[verif/slew_limited_motor_drive_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slew_limited_motor_drive_tb - testbench of the slew limited motor drive
// Drives set-target words and update ticks in random bursts under a random
// output stall pattern, including one long hold-off that backs up the block.
// A directed opening hits field extremes, slew rule branches, rounding,
// reversal and clamping; random phases then run under varied register
// settings. The checker predicts and compares every drive word.
// ----------------------------------------------------------------------------
module slew_limited_motor_drive_tb;
    import sld_pkg::*;
    import sld_tb_pkg::*;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} t_stall_mode;

    localparam int HOLD_CYCLES  = 80;
    localparam int ITEMS_PHASE  = 125;
    localparam int RANDOM_PHASES = 10;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_word              in_word  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    int ticks;
    int targets;
    int settings   = 0;
    int burst_left = 8;
    bit hold_req   = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    slew_limited_motor_drive dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_word     (in_word),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_word     (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    slew_limited_motor_drive_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_ticks      (ticks),
        .o_targets    (targets)
    );

    function automatic t_in_word target_word(input int pct);
        t_in_word w;
        w.func         = FUNC_SET_TARGET;
        w.req_power    = 8'(pct);
        w.interval_ms  = 10'($urandom);
        return w;
    endfunction

    function automatic t_in_word tick_word(input int ms);
        t_in_word w;
        w.func         = FUNC_TICK;
        w.req_power    = 8'($urandom);
        w.interval_ms  = 10'(ms);
        return w;
    endfunction

    task automatic push_word(input t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // bursts of back to back words with random gaps in between
    task automatic offer(input t_in_word w);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push_word(w);
    endtask

    task automatic drain(input int limit);
        in_valid <= 1'b0;
        @(posedge clk);
        for (int c = 0; c < limit && pending != 0; c++) @(posedge clk);
        burst_left = $urandom_range(1, 24);
    endtask

    task automatic set_config(input logic en, input logic [9:0] step,
                              input logic rev, input logic [3:0] port);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SLEW_ENABLE;
        cfg_data <= CFG_DATA_W'(en);
        @(posedge clk);
        cfg_idx  <= CFG_SLEW_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_idx  <= CFG_REVERSED;
        cfg_data <= CFG_DATA_W'(rev);
        @(posedge clk);
        cfg_idx  <= CFG_MOTOR_PORT;
        cfg_data <= CFG_DATA_W'(port);
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings++;
    endtask

    task automatic random_word();
        int ms, pct;
        if ($urandom_range(0, 99) < 60) begin
            ms = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
            offer(tick_word(ms));
        end else begin
            if ($urandom_range(0, 7) == 0) pct = int'($urandom_range(0, 255)) - 128;
            else pct = int'($urandom_range(0, 200)) - 100;
            offer(target_word(pct));
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin
        t_stall_mode mode;
        int span;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 48);
            for (int k = 0; k < span && !hold_req; k++) begin
                case (mode)
                    STALL_NONE:      out_stall <= 1'b0;
                    STALL_LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:     out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_ALTERNATE: out_stall <= k[0];
                    default:         out_stall <= 1'b0;
                endcase
                @(posedge clk);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial begin
        #10ms;
        $display("run timed out");
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int en_tab   [5] = '{1, 1, 1, 0, 1};
        int step_tab [5] = '{171, 1023, 1, 0, 0};
        int rev_tab  [5] = '{0, 1, 0, 1, 0};
        int port_tab [5] = '{3, 15, 0, 15, 7};
        logic       en;
        logic [9:0] step;
        logic       rev;
        logic [3:0] port;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: ramp up, clamp, sign cancel, smaller target jump
        offer(target_word(100));
        offer(tick_word(1));
        offer(tick_word(1023));
        offer(tick_word(0));
        offer(target_word(-127));
        offer(tick_word(1023));
        offer(tick_word(1023));
        offer(target_word(0));
        offer(tick_word(7));
        offer(target_word(20));
        offer(tick_word(0));
        offer(tick_word(1023));
        offer(target_word(10));
        offer(tick_word(1));
        offer(target_word(-128));
        offer(tick_word(2));
        offer(tick_word(1023));
        drain(2000);

        // half step rounding and reversal
        set_config(1'b1, 10'd128, 1'b1, 4'd15);
        offer(target_word(1));
        offer(tick_word(1));
        offer(target_word(-1));
        offer(tick_word(1));
        offer(tick_word(1));
        offer(target_word(100));
        offer(tick_word(1023));
        drain(2000);

        // slew off: direct load beyond full scale
        set_config(1'b0, 10'd1023, 1'b0, 4'd9);
        offer(target_word(127));
        offer(tick_word(0));
        offer(target_word(-128));
        offer(tick_word(5));
        drain(2000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 5) begin
                en   = en_tab[ph][0];
                step = 10'(step_tab[ph]);
                rev  = rev_tab[ph][0];
                port = 4'(port_tab[ph]);
            end else begin
                en   = ($urandom_range(0, 3) != 0);
                step = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(1, 64)) : 10'($urandom);
                rev  = 1'($urandom);
                port = 4'($urandom);
            end
            set_config(en, step, rev, port);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if (ph == 0 && n == 20) begin
                    hold_req = 1'b1;
                    for (int b = 0; b < 40; b++) begin
                        if ($urandom_range(0, 1) == 0) push_word(tick_word($urandom_range(0, 12)));
                        else push_word(target_word(int'($urandom_range(0, 200)) - 100));
                    end
                    n += 40;
                end
                random_word();
            end
            drain(20000);
        end

        repeat (10) @(posedge clk);
        if (pending != 0) begin
            $error("%0d expected drive words never came out", pending);
        end
        $display("covered %0d update ticks and %0d set-target words", ticks, targets);
        $display("over %0d register settings with random bursts and stalls", settings + 1);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
rtl/sld_pkg.sv
rtl/sld_ram.sv
rtl/slew_limited_motor_drive.sv
verif/sld_tb_pkg.sv
verif/slew_limited_motor_drive_checker.sv
verif/slew_limited_motor_drive_tb.sv
